FILE: hw/rtl/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    typedef struct packed {
        logic        mode;
        logic [31:0] size_bytes;
        logic [31:0] free_address;
    } t_cmd;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE
    } t_state;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_MEMORY = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

    // Table entry flags.
    localparam logic [7:0] ENTRY_TYPE_MASK = 8'h0f;
    localparam logic [2:0] FLAG_TAKEN      = 3'b001;
    localparam logic [2:0] FLAG_FIRST      = 3'b010;
    localparam logic [2:0] FLAG_HAS_NEXT   = 3'b100;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_HEAP_BASE   = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_BLOCK_COUNT = 3'd4;

    localparam logic [31:0] HEAP_BASE_RESET   = 32'd0;
    localparam logic [10:0] BLOCK_COUNT_RESET = 11'd1024;

endpackage : ffba_pkg
`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator over a block table held in one synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the block clears its table, one entry per cycle; busy is high
// meanwhile and configuration writes are still taken. A command is taken
// when start is high and busy is low. Its result appears on o_result for
// exactly one cycle, marked by o_done, and the receiver cannot stall it. A
// request that is rejected at once (zero size, more blocks than the configured
// block count, free address outside the heap) reports in the cycle after it
// is taken and leaves busy low. An allocation otherwise scans the table
// through the RAM read port, one entry per cycle, and, if it finds a
// free run, writes the run one entry per cycle. A free walks the has-next
// chain with one entry read and one entry written per cycle. BLOCK_BYTES
// must be a power of two.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire ffba_pkg::t_cmd              i_cmd,
    output logic                             o_done,
    output ffba_pkg::t_result                o_result,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [ffba_pkg::PADDR_W-1:0]      paddr,
    input  wire [31:0]                       pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int SHIFT = $clog2(BLOCK_BYTES);
    localparam int LW    = 33 - SHIFT;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);

    // Configuration registers.
    logic [31:0] r_heap_base;
    logic [10:0] r_block_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base   <= ffba_pkg::HEAP_BASE_RESET;
            r_block_count <= ffba_pkg::BLOCK_COUNT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == ffba_pkg::ADDR_HEAP_BASE) begin
                r_heap_base <= pwdata;
            end else if (paddr == ffba_pkg::ADDR_BLOCK_COUNT) begin
                r_block_count <= pwdata[10:0];
            end
        end
    end

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr == ffba_pkg::ADDR_HEAP_BASE) begin
            prdata = r_heap_base;
        end else if (paddr == ffba_pkg::ADDR_BLOCK_COUNT) begin
            prdata = 32'(r_block_count);
        end
    end

    // Control and datapath registers.
    ffba_pkg::t_state  r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_cidx;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_run, n_run;
    logic [CW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_first, n_first;
    logic              r_done, n_done;
    ffba_pkg::t_result r_res, n_res;

    // Block table RAM.
    logic [2:0]    mem [MAX_BLOCKS];
    logic [2:0]    r_rdata;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [2:0]    w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    // Derived request values.
    logic [CW-1:0] w_total;
    logic [LW-1:0] w_len;
    logic          w_alloc_reject;
    logic [31:0]   w_off;
    logic [31:0]   w_fidx;
    logic          w_free_outside;

    always_comb begin
        if (32'(r_block_count) > 32'(MAX_BLOCKS)) begin
            w_total = CW'(MAX_BLOCKS);
        end else begin
            w_total = CW'(r_block_count);
        end
        w_len = LW'(i_cmd.size_bytes >> SHIFT)
              + LW'(|i_cmd.size_bytes[SHIFT-1:0]);
        w_alloc_reject = (w_len == '0) || (33'(w_len) > 33'(w_total));
        w_off  = i_cmd.free_address - r_heap_base;
        w_fidx = w_off >> SHIFT;
        w_free_outside = (i_cmd.free_address < r_heap_base) ||
                         (w_fidx >= 32'(w_total));
    end

    // Evaluation of the entry that the RAM returned this cycle.
    logic w_taken;
    logic w_found;
    logic w_last;
    logic w_chain_end;
    logic w_mark_last;

    always_comb begin
        w_taken     = ((8'(r_rdata) & ffba_pkg::ENTRY_TYPE_MASK
                        & 8'(ffba_pkg::FLAG_TAKEN)) != 8'd0);
        w_found     = !w_taken && ((r_run + CW'(1)) == r_len);
        w_last      = (CW'(r_cidx) + CW'(1)) == w_total;
        w_chain_end = ((r_rdata & ffba_pkg::FLAG_HAS_NEXT) == 3'd0) || w_last;
        w_mark_last = (r_k + CW'(1)) == r_len;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::ST_CLEAR: begin
                if (r_idx == LAST_IDX) n_state = ffba_pkg::ST_IDLE;
            end
            ffba_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_cmd.mode == ffba_pkg::MODE_ALLOC) begin
                        if (!w_alloc_reject) n_state = ffba_pkg::ST_SCAN;
                    end else if (!w_free_outside) begin
                        n_state = ffba_pkg::ST_FREE;
                    end
                end
            end
            ffba_pkg::ST_SCAN: begin
                if (r_pend && w_found) begin
                    n_state = ffba_pkg::ST_MARK;
                end else if (r_pend && w_last) begin
                    n_state = ffba_pkg::ST_IDLE;
                end
            end
            ffba_pkg::ST_MARK: begin
                if (w_mark_last) n_state = ffba_pkg::ST_IDLE;
            end
            ffba_pkg::ST_FREE: begin
                if (r_pend && w_chain_end) n_state = ffba_pkg::ST_IDLE;
            end
            default: n_state = ffba_pkg::ST_IDLE;
        endcase
    end

    // Outputs, RAM write port and datapath updates.
    always_comb begin
        n_idx   = r_idx + IW'(1);
        n_run   = r_run;
        n_len   = r_len;
        n_k     = r_k;
        n_first = r_first;
        n_done  = 1'b0;
        n_res   = '{alloc_address: '0, status: ffba_pkg::STATUS_OK};
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = 3'd0;
        unique case (r_state)
            ffba_pkg::ST_CLEAR: begin
                w_we = 1'b1;
            end
            ffba_pkg::ST_IDLE: begin
                n_run = '0;
                n_k   = '0;
                n_len = CW'(w_len);
                if (start) begin
                    if (i_cmd.mode == ffba_pkg::MODE_ALLOC) begin
                        n_idx = '0;
                        if (w_alloc_reject) begin
                            n_done       = 1'b1;
                            n_res.status = ffba_pkg::STATUS_NO_MEMORY;
                        end
                    end else begin
                        n_idx = IW'(w_fidx);
                        if (w_free_outside) begin
                            n_done       = 1'b1;
                            n_res.status = ffba_pkg::STATUS_OUTSIDE;
                        end
                    end
                end
            end
            ffba_pkg::ST_SCAN: begin
                if (r_pend) begin
                    if (w_taken) begin
                        n_run = '0;
                    end else begin
                        n_run = r_run + CW'(1);
                        if (r_run == '0) n_first = r_cidx;
                    end
                    if (!w_found && w_last) begin
                        n_done       = 1'b1;
                        n_res.status = ffba_pkg::STATUS_NO_MEMORY;
                    end
                end
            end
            ffba_pkg::ST_MARK: begin
                w_we    = 1'b1;
                w_waddr = r_first + IW'(r_k);
                w_wdata = ffba_pkg::FLAG_TAKEN;
                if (r_k == '0) w_wdata = w_wdata | ffba_pkg::FLAG_FIRST;
                if (!w_mark_last) w_wdata = w_wdata | ffba_pkg::FLAG_HAS_NEXT;
                n_k = r_k + CW'(1);
                if (w_mark_last) begin
                    n_done = 1'b1;
                    n_res.alloc_address = r_heap_base
                                        + 32'(64'(r_first) << SHIFT);
                end
            end
            ffba_pkg::ST_FREE: begin
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_cidx;
                    if (w_chain_end) n_done = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
        // Read data is meaningful only when its read was issued in the same reading state.
        n_pend = ((r_state == ffba_pkg::ST_SCAN) || (r_state == ffba_pkg::ST_FREE))
                 && (n_state == r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx  <= r_idx;
        r_run   <= n_run;
        r_len   <= n_len;
        r_k     <= n_k;
        r_first <= n_first;
        r_res   <= n_res;
    end

    assign busy     = (r_state != ffba_pkg::ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // A failed request never reports an address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.status != ffba_pkg::STATUS_OK)
        |-> o_result.alloc_address == 32'd0)
        else $error("failed request reported a nonzero address");

    // An accepted transaction either reports at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted transaction neither reported nor started");

    // The first-fit scan only reads the table.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::ST_SCAN) |-> !w_we)
        else $error("table written during scan");

    // Every allocation run is written starting with a first-block entry.
    a_mark_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::ST_MARK) && (r_k == '0)
        |-> (w_wdata & ffba_pkg::FLAG_FIRST) != 3'd0)
        else $error("run written without first flag");

endmodule : first_fit_block_allocator_top
`default_nettype wire
